### sv/rtbs_pkg.sv
package rtbs_pkg;

    localparam int WORD_W   = 32;
    localparam int BUDGET_W = 22;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET  = BUDGET_W'(33000);
    localparam logic [BUDGET_W-1:0] MIN_BUDGET_US = BUDGET_W'(20000);

    // overheads in microseconds
    localparam logic [WORD_W-1:0] START_OVH = WORD_W'(1910);
    localparam logic [WORD_W-1:0] END_OVH   = WORD_W'(960);
    localparam logic [WORD_W-1:0] MSRC_OVH  = WORD_W'(660);
    localparam logic [WORD_W-1:0] TCC_OVH   = WORD_W'(590);
    localparam logic [WORD_W-1:0] DSS_OVH   = WORD_W'(690);
    localparam logic [WORD_W-1:0] PRE_OVH   = WORD_W'(660);
    localparam logic [WORD_W-1:0] FINAL_OVH = WORD_W'(550);

    // 2304 * 1655: pclk period to macro period scale, in ps
    localparam logic [WORD_W-1:0] MP_SCALE = WORD_W'(2304 * 1655);
    localparam logic [WORD_W-1:0] NS_DIV   = WORD_W'(1000);
    localparam logic [WORD_W-1:0] NS_ROUND = WORD_W'(500);

    localparam int SEQ_MSRC  = 2;
    localparam int SEQ_DSS   = 3;
    localparam int SEQ_TCC   = 4;
    localparam int SEQ_PRE   = 6;
    localparam int SEQ_FINAL = 7;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_LOW_BUDGET = 2'd1;
    localparam logic [1:0] STATUS_NO_FINAL   = 2'd2;
    localparam logic [1:0] STATUS_EXHAUSTED  = 2'd3;

    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_DIV = 1'b1;

    typedef struct packed {
        logic [7:0] sequence_config;
        logic [6:0] pre_period_code;
        logic [6:0] final_period_code;
        logic [7:0] short_step_timeout_code;
        logic [7:0] pre_timeout_mantissa;
        logic [4:0] pre_timeout_exponent;
    } item_t;

    typedef struct packed {
        logic [15:0] final_timeout_code;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic go;
        logic op;
    } alu_ctl_t;

endpackage

### sv/rtbs_serial_alu.sv
module rtbs_serial_alu #(
    parameter int WIDTH = rtbs_pkg::WORD_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rtbs_pkg::alu_ctl_t  ctl,
    input  logic [WIDTH-1:0]    a,
    input  logic [WIDTH-1:0]    b,
    output logic                done,
    output logic [WIDTH-1:0]    y
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic             op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] rem_reg, rem_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign trial = {rem_reg, a_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, b_reg};
    assign fits  = (trial >= {1'b0, b_reg});

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        if (ctl.go)
        begin
            active_next = 1'b1;
            op_next     = ctl.op;
            cnt_next    = '0;
            a_next      = a;
            b_next      = b;
            acc_next    = '0;
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            // one multiplier bit or one quotient bit per cycle
            a_next = a_reg << 1;
            if (op_reg == rtbs_pkg::ALU_MUL)
            begin
                b_next = b_reg >> 1;
                if (b_reg[0])
                begin
                    acc_next = acc_reg + a_reg;
                end
            end
            else
            begin
                if (fits)
                begin
                    rem_next = diff[WIDTH-1:0];
                    acc_next = {acc_reg[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[WIDTH-1:0];
                    acc_next = {acc_reg[WIDTH-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign y    = acc_reg;

endmodule

### sv/ranging_timing_budget_solver.sv
// channel  | handshake       | payload                 | notes
// ---------+-----------------+-------------------------+------------------------------
// command  | start / busy    | cmd (item_t)            | taken when start & !busy
// result   | done            | result (result_t)       | one word, valid for one cycle
// config   | cfg_we          | cfg_wdata (22 bit)      | timing budget, us; write idle
//
// Low budget or disabled final step: the result word follows in the next cycle.
// Otherwise eight operations on one shared bit-serial multiply/divide unit, a budget
// check and, unless the budget is exhausted, two more operations and a normalizing
// shift of up to 24 steps. On the ALU path busy is high until the result is out;
// rst_n clears control state and loads the budget. The result port has no back
// pressure; a new command may start in the done cycle.
module ranging_timing_budget_solver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  rtbs_pkg::item_t                 cmd,
    output logic                            done,
    output rtbs_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [rtbs_pkg::BUDGET_W-1:0]   cfg_wdata
);

    localparam int W = rtbs_pkg::WORD_W;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_PMP_MUL   = 4'd1;
    localparam logic [3:0] ST_PMP_DIV   = 4'd2;
    localparam logic [3:0] ST_FMP_MUL   = 4'd3;
    localparam logic [3:0] ST_FMP_DIV   = 4'd4;
    localparam logic [3:0] ST_SH_MUL    = 4'd5;
    localparam logic [3:0] ST_SH_DIV    = 4'd6;
    localparam logic [3:0] ST_PR_MUL    = 4'd7;
    localparam logic [3:0] ST_PR_DIV    = 4'd8;
    localparam logic [3:0] ST_ACC_TCC   = 4'd9;
    localparam logic [3:0] ST_ACC_SHORT = 4'd10;
    localparam logic [3:0] ST_ACC_PRE   = 4'd11;
    localparam logic [3:0] ST_CHECK     = 4'd12;
    localparam logic [3:0] ST_REST_MUL  = 4'd13;
    localparam logic [3:0] ST_REST_DIV  = 4'd14;
    localparam logic [3:0] ST_PACK      = 4'd15;

    logic [3:0]                     state_reg, state_next;
    logic [rtbs_pkg::BUDGET_W-1:0]  budget_reg, budget_next;
    logic                           done_reg, done_next;
    rtbs_pkg::result_t              result_reg, result_next;
    rtbs_pkg::alu_ctl_t             ctl_reg, ctl_next;
    logic [W-1:0]                   opa_reg, opa_next;
    logic [W-1:0]                   opb_reg, opb_next;

    logic [7:0]                     seq_reg, seq_next;
    logic [6:0]                     fin_code_reg, fin_code_next;
    logic [7:0]                     short_code_reg, short_code_next;
    logic [W-1:0]                   pre_clk_reg, pre_clk_next;
    logic [W-1:0]                   pre_mp_reg, pre_mp_next;
    logic [W-1:0]                   fin_mp_reg, fin_mp_next;
    logic [W-1:0]                   short_us_reg, short_us_next;
    logic [W-1:0]                   pre_us_reg, pre_us_next;
    logic [W-1:0]                   used_reg, used_next;
    logic [W-1:0]                   lo_reg, lo_next;
    logic [4:0]                     exp_reg, exp_next;

    logic                           alu_done;
    logic [W-1:0]                   alu_y;

    logic [8:0]                     fin_period;
    logic [W-1:0]                   clocks;
    logic [W-1:0]                   budget_w;

    assign fin_period = ({2'b00, fin_code_reg} + 9'd1) << 1;
    assign clocks     = alu_y + (seq_reg[rtbs_pkg::SEQ_PRE] ? pre_clk_reg : '0);
    assign budget_w   = W'(budget_reg);

    rtbs_serial_alu #(
        .WIDTH (W)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_reg),
        .a     (opa_reg),
        .b     (opb_reg),
        .done  (alu_done),
        .y     (alu_y)
    );

    always_comb
    begin
        state_next      = state_reg;
        budget_next     = budget_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        ctl_next        = '0;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        seq_next        = seq_reg;
        fin_code_next   = fin_code_reg;
        short_code_next = short_code_reg;
        pre_clk_next    = pre_clk_reg;
        pre_mp_next     = pre_mp_reg;
        fin_mp_next     = fin_mp_reg;
        short_us_next   = short_us_reg;
        pre_us_next     = pre_us_reg;
        used_next       = used_reg;
        lo_next         = lo_reg;
        exp_next        = exp_reg;

        if (cfg_we)
        begin
            budget_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    seq_next        = cmd.sequence_config;
                    fin_code_next   = cmd.final_period_code;
                    short_code_next = cmd.short_step_timeout_code;
                    pre_clk_next    = (W'(cmd.pre_timeout_mantissa)
                                       << cmd.pre_timeout_exponent) + W'(1);
                    if (budget_reg < rtbs_pkg::MIN_BUDGET_US)
                    begin
                        done_next   = 1'b1;
                        result_next = '{final_timeout_code: '0,
                                        status: rtbs_pkg::STATUS_LOW_BUDGET};
                    end
                    else if (!cmd.sequence_config[rtbs_pkg::SEQ_FINAL])
                    begin
                        done_next   = 1'b1;
                        result_next = '{final_timeout_code: '0,
                                        status: rtbs_pkg::STATUS_NO_FINAL};
                    end
                    else
                    begin
                        ctl_next   = '{go: 1'b1, op: rtbs_pkg::ALU_MUL};
                        opa_next   = W'({2'b00, cmd.pre_period_code} + 9'd1) << 1;
                        opb_next   = rtbs_pkg::MP_SCALE;
                        state_next = ST_PMP_MUL;
                    end
                end
            end
            ST_PMP_MUL:
            begin
                if (alu_done)
                begin
                    ctl_next   = '{go: 1'b1, op: rtbs_pkg::ALU_DIV};
                    opa_next   = alu_y + rtbs_pkg::NS_ROUND;
                    opb_next   = rtbs_pkg::NS_DIV;
                    state_next = ST_PMP_DIV;
                end
            end
            ST_PMP_DIV:
            begin
                if (alu_done)
                begin
                    pre_mp_next = alu_y;
                    ctl_next    = '{go: 1'b1, op: rtbs_pkg::ALU_MUL};
                    opa_next    = W'(fin_period);
                    opb_next    = rtbs_pkg::MP_SCALE;
                    state_next  = ST_FMP_MUL;
                end
            end
            ST_FMP_MUL:
            begin
                if (alu_done)
                begin
                    ctl_next   = '{go: 1'b1, op: rtbs_pkg::ALU_DIV};
                    opa_next   = alu_y + rtbs_pkg::NS_ROUND;
                    opb_next   = rtbs_pkg::NS_DIV;
                    state_next = ST_FMP_DIV;
                end
            end
            ST_FMP_DIV:
            begin
                if (alu_done)
                begin
                    fin_mp_next = alu_y;
                    ctl_next    = '{go: 1'b1, op: rtbs_pkg::ALU_MUL};
                    opa_next    = W'({1'b0, short_code_reg} + 9'd1);
                    opb_next    = pre_mp_reg;
                    state_next  = ST_SH_MUL;
                end
            end
            ST_SH_MUL:
            begin
                if (alu_done)
                begin
                    ctl_next   = '{go: 1'b1, op: rtbs_pkg::ALU_DIV};
                    opa_next   = alu_y + rtbs_pkg::NS_ROUND;
                    opb_next   = rtbs_pkg::NS_DIV;
                    state_next = ST_SH_DIV;
                end
            end
            ST_SH_DIV:
            begin
                if (alu_done)
                begin
                    short_us_next = alu_y;
                    ctl_next      = '{go: 1'b1, op: rtbs_pkg::ALU_MUL};
                    opa_next      = pre_clk_reg;
                    opb_next      = pre_mp_reg;
                    state_next    = ST_PR_MUL;
                end
            end
            ST_PR_MUL:
            begin
                if (alu_done)
                begin
                    ctl_next   = '{go: 1'b1, op: rtbs_pkg::ALU_DIV};
                    opa_next   = alu_y + rtbs_pkg::NS_ROUND;
                    opb_next   = rtbs_pkg::NS_DIV;
                    state_next = ST_PR_DIV;
                end
            end
            ST_PR_DIV:
            begin
                if (alu_done)
                begin
                    pre_us_next = alu_y;
                    used_next   = rtbs_pkg::START_OVH + rtbs_pkg::END_OVH;
                    state_next  = ST_ACC_TCC;
                end
            end
            ST_ACC_TCC:
            begin
                if (seq_reg[rtbs_pkg::SEQ_TCC])
                begin
                    used_next = used_reg + short_us_reg + rtbs_pkg::TCC_OVH;
                end
                state_next = ST_ACC_SHORT;
            end
            ST_ACC_SHORT:
            begin
                // dss takes precedence over msrc
                if (seq_reg[rtbs_pkg::SEQ_DSS])
                begin
                    used_next = used_reg + (short_us_reg << 1) + (rtbs_pkg::DSS_OVH << 1);
                end
                else if (seq_reg[rtbs_pkg::SEQ_MSRC])
                begin
                    used_next = used_reg + short_us_reg + rtbs_pkg::MSRC_OVH;
                end
                state_next = ST_ACC_PRE;
            end
            ST_ACC_PRE:
            begin
                if (seq_reg[rtbs_pkg::SEQ_PRE])
                begin
                    used_next = used_reg + pre_us_reg
                                + (rtbs_pkg::PRE_OVH + rtbs_pkg::FINAL_OVH);
                end
                else
                begin
                    used_next = used_reg + rtbs_pkg::FINAL_OVH;
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (used_reg > budget_w)
                begin
                    done_next   = 1'b1;
                    result_next = '{final_timeout_code: '0,
                                    status: rtbs_pkg::STATUS_EXHAUSTED};
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ctl_next   = '{go: 1'b1, op: rtbs_pkg::ALU_MUL};
                    opa_next   = budget_w - used_reg;
                    opb_next   = rtbs_pkg::NS_DIV;
                    state_next = ST_REST_MUL;
                end
            end
            ST_REST_MUL:
            begin
                if (alu_done)
                begin
                    ctl_next   = '{go: 1'b1, op: rtbs_pkg::ALU_DIV};
                    opa_next   = alu_y + (fin_mp_reg >> 1);
                    opb_next   = fin_mp_reg;
                    state_next = ST_REST_DIV;
                end
            end
            ST_REST_DIV:
            begin
                if (alu_done)
                begin
                    if (clocks == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '{final_timeout_code: '0,
                                        status: rtbs_pkg::STATUS_OK};
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        lo_next    = clocks - W'(1);
                        exp_next   = '0;
                        state_next = ST_PACK;
                    end
                end
            end
            ST_PACK:
            begin
                // shift right until the mantissa fits in a byte
                if (lo_reg[W-1:8] != '0)
                begin
                    lo_next  = lo_reg >> 1;
                    exp_next = exp_reg + 5'd1;
                end
                else
                begin
                    done_next   = 1'b1;
                    result_next = '{final_timeout_code: {3'b000, exp_reg, lo_reg[7:0]},
                                    status: rtbs_pkg::STATUS_OK};
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            budget_reg <= rtbs_pkg::BUDGET_RESET;
            done_reg   <= 1'b0;
            ctl_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            budget_reg <= budget_next;
            done_reg   <= done_next;
            ctl_reg    <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        opa_reg        <= opa_next;
        opb_reg        <= opb_next;
        seq_reg        <= seq_next;
        fin_code_reg   <= fin_code_next;
        short_code_reg <= short_code_next;
        pre_clk_reg    <= pre_clk_next;
        pre_mp_reg     <= pre_mp_next;
        fin_mp_reg     <= fin_mp_next;
        short_us_reg   <= short_us_next;
        pre_us_reg     <= pre_us_next;
        used_reg       <= used_next;
        lo_reg         <= lo_next;
        exp_reg        <= exp_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### test/tb_ranging_timing_budget_solver.sv
`timescale 1ns / 100ps

module tb_ranging_timing_budget_solver;

    typedef logic [rtbs_pkg::WORD_W-1:0] word_t;

    class timeout_scoreboard;
        rtbs_pkg::result_t               expected_words[$];
        logic [rtbs_pkg::BUDGET_W-1:0]   budget;
        int                              errors;

        function new();
            budget = rtbs_pkg::BUDGET_RESET;
            errors = 0;
        endfunction

        function word_t code_to_macro_ns(logic [6:0] code);
            word_t period;
            period = (word_t'(code) + word_t'(1)) * word_t'(2);
            return (rtbs_pkg::MP_SCALE * period + rtbs_pkg::NS_ROUND) / rtbs_pkg::NS_DIV;
        endfunction

        function word_t clocks_to_us(word_t clocks, word_t mp);
            return (clocks * mp + rtbs_pkg::NS_ROUND) / rtbs_pkg::NS_DIV;
        endfunction

        function rtbs_pkg::result_t solve_timeout(rtbs_pkg::item_t c);
            rtbs_pkg::result_t r;
            word_t   pre_mp;
            word_t   fin_mp;
            word_t   short_us;
            word_t   pre_clk;
            word_t   used;
            word_t   rest;
            word_t   clocks;
            word_t   lo;
            word_t   hi;
            r = '0;
            if (budget < rtbs_pkg::MIN_BUDGET_US)
            begin
                r.status = rtbs_pkg::STATUS_LOW_BUDGET;
                return r;
            end
            pre_mp   = code_to_macro_ns(c.pre_period_code);
            fin_mp   = code_to_macro_ns(c.final_period_code);
            short_us = clocks_to_us(word_t'(c.short_step_timeout_code) + word_t'(1), pre_mp);
            pre_clk  = (word_t'(c.pre_timeout_mantissa) << c.pre_timeout_exponent)
                       + word_t'(1);

            used = rtbs_pkg::START_OVH + rtbs_pkg::END_OVH;
            if (c.sequence_config[rtbs_pkg::SEQ_TCC])
                used = used + short_us + rtbs_pkg::TCC_OVH;
            // dss covers msrc when both are on
            if (c.sequence_config[rtbs_pkg::SEQ_DSS])
                used = used + word_t'(2) * (short_us + rtbs_pkg::DSS_OVH);
            else if (c.sequence_config[rtbs_pkg::SEQ_MSRC])
                used = used + short_us + rtbs_pkg::MSRC_OVH;
            if (c.sequence_config[rtbs_pkg::SEQ_PRE])
                used = used + clocks_to_us(pre_clk, pre_mp) + rtbs_pkg::PRE_OVH;

            if (!c.sequence_config[rtbs_pkg::SEQ_FINAL])
            begin
                r.status = rtbs_pkg::STATUS_NO_FINAL;
                return r;
            end
            used = used + rtbs_pkg::FINAL_OVH;
            if (used > word_t'(budget))
            begin
                r.status = rtbs_pkg::STATUS_EXHAUSTED;
                return r;
            end

            rest   = word_t'(budget) - used;
            clocks = (rest * rtbs_pkg::NS_DIV + (fin_mp >> 1)) / fin_mp;
            if (c.sequence_config[rtbs_pkg::SEQ_PRE])
                clocks = clocks + pre_clk;

            if (clocks != '0)
            begin
                lo = clocks - word_t'(1);
                hi = '0;
                while (lo[31:8] != '0)
                begin
                    lo = lo >> 1;
                    hi = hi + word_t'(1);
                end
                r.final_timeout_code = {hi[7:0], lo[7:0]};
            end
            r.status = rtbs_pkg::STATUS_OK;
            return r;
        endfunction

        function void note_command(rtbs_pkg::item_t c);
            expected_words.push_back(solve_timeout(c));
        endfunction

        function void check_word(rtbs_pkg::result_t got);
            rtbs_pkg::result_t want;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: final_timeout_code %h status %0d",
                       got.final_timeout_code, got.status);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.final_timeout_code !== want.final_timeout_code)
            begin
                $error("final_timeout_code: expected %h, got %h",
                       want.final_timeout_code, got.final_timeout_code);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    rtbs_pkg::item_t                 cmd;
    logic                            done;
    rtbs_pkg::result_t               result;
    logic                            cfg_we;
    logic [rtbs_pkg::BUDGET_W-1:0]   cfg_wdata;

    timeout_scoreboard     sb;

    ranging_timing_budget_solver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_word(result);
            if (start && !busy)
                sb.note_command(cmd);
        end
    end

    function automatic int idle_gap(int idx);
        int r;
        // leave some back-to-back stretches
        if (idx % 64 < 12)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(30, 80);
    endfunction

    function automatic rtbs_pkg::item_t random_item();
        rtbs_pkg::item_t w;
        w.sequence_config         = 8'($urandom_range(0, 255));
        w.pre_period_code         = 7'($urandom_range(0, 127));
        w.final_period_code       = 7'($urandom_range(0, 127));
        w.short_step_timeout_code = 8'($urandom_range(0, 255));
        w.pre_timeout_mantissa    = 8'($urandom_range(0, 255));
        w.pre_timeout_exponent    = 5'($urandom_range(0, 31));
        // mostly sensor-like setups so the ok path gets exercised
        if ($urandom_range(0, 9) < 7)
        begin
            if ($urandom_range(0, 9) != 0)
                w.sequence_config[rtbs_pkg::SEQ_FINAL] = 1'b1;
            w.pre_period_code         = 7'($urandom_range(4, 9));
            w.final_period_code       = 7'($urandom_range(2, 7));
            w.short_step_timeout_code = 8'($urandom_range(0, 40));
            w.pre_timeout_exponent    = 5'($urandom_range(0, 4));
        end
        return w;
    endfunction

    task automatic send_word(rtbs_pkg::item_t w, int gap);
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic [7:0] seq, logic [6:0] pre_code, logic [6:0] fin_code,
                               logic [7:0] short_code, logic [7:0] mant, logic [4:0] expo);
        rtbs_pkg::item_t w;
        w.sequence_config         = seq;
        w.pre_period_code         = pre_code;
        w.final_period_code       = fin_code;
        w.short_step_timeout_code = short_code;
        w.pre_timeout_mantissa    = mant;
        w.pre_timeout_exponent    = expo;
        send_word(w, $urandom_range(0, 2));
    endtask

    // wait on the falling edge so the monitor has settled
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_words.size() != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_budget(logic [rtbs_pkg::BUDGET_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.budget = value;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_word(random_item(), idle_gap(i));
    endtask

    initial
    begin
        logic [rtbs_pkg::BUDGET_W-1:0] budgets[8];
        int                            counts[8];
        sb = new();
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset budget
        send_fields(8'h00,   7'd0,   7'd0,   8'd0,   8'd0,   5'd0);
        send_fields(8'h80,   7'd0,   7'd0,   8'd0,   8'd0,   5'd0);
        send_fields(8'hFF, 7'd127, 7'd127, 8'd255, 8'd255,  5'd31);
        send_fields(8'hFF,   7'd0,   7'd0,   8'd0,   8'd0,   5'd0);
        send_fields(8'h80, 7'd127, 7'd127,   8'd0,   8'd0,   5'd0);
        send_fields(8'h90,   7'd0,   7'd5,   8'd0,   8'd0,   5'd0);
        send_fields(8'h88,   7'd3,   7'd4,  8'd10,   8'd0,   5'd0);
        send_fields(8'h84,   7'd3,   7'd4,  8'd10,   8'd0,   5'd0);
        send_fields(8'h8C,   7'd3,   7'd4,  8'd10,   8'd0,   5'd0);
        send_fields(8'hC0,   7'd6,   7'd4,   8'd0, 8'd255,   5'd0);
        send_fields(8'hC0,   7'd6,   7'd4,   8'd0, 8'd255,  5'd23);
        send_fields(8'hC0,   7'd6,   7'd4,   8'd0, 8'd255,  5'd31);
        send_fields(8'hC0,   7'd6,   7'd4,   8'd0,   8'd1,  5'd31);
        send_fields(8'h40,   7'd6,   7'd4,   8'd0,   8'd1,   5'd0);
        send_fields(8'h23,   7'd0,   7'd0,   8'd0,   8'd0,   5'd0);
        send_fields(8'hA3,   7'd2,   7'd2,   8'd0,   8'd0,   5'd0);
        send_fields(8'hDC,   7'd6,   7'd4, 8'd255, 8'd255,   5'd0);
        send_fields(8'hD4,   7'd5,   7'd3,  8'd20, 8'd100,   5'd2);
        send_fields(8'h80, 7'd126,   7'd0,   8'd0,   8'd0,   5'd0);
        drain();

        // budget equal to the used time: zero total, then one step more exhausts it
        write_budget(rtbs_pkg::BUDGET_W'(755081));
        send_fields(8'h98, 7'd127, 7'd127, 8'd255,   8'd0,   5'd0);
        send_fields(8'hD8, 7'd127, 7'd127, 8'd255,   8'd0,   5'd0);
        drain();

        budgets = '{rtbs_pkg::BUDGET_W'(20000), rtbs_pkg::BUDGET_W'(19999),
                    rtbs_pkg::BUDGET_W'(0), rtbs_pkg::BUDGET_W'(4000000),
                    {rtbs_pkg::BUDGET_W{1'b1}},
                    rtbs_pkg::BUDGET_W'($urandom_range(20000, 4000000)),
                    rtbs_pkg::BUDGET_W'($urandom_range(20000, 200000)),
                    rtbs_pkg::BUDGET_RESET};
        counts  = '{240, 40, 40, 240, 240, 240, 240, 240};
        for (int p = 0; p < 8; p++)
        begin
            write_budget(budgets[p]);
            run_random(counts[p]);
            drain();
        end

        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(30_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
